### rtl/dth_pkg.sv
`default_nettype none
package dth_pkg;
  localparam int HeapDepth   = 64;
  localparam int Connections = 1024;
  localparam int HeapAw      = $clog2(HeapDepth);
  localparam int CountW      = $clog2(HeapDepth + 1);
  localparam int ConnW       = 10;
  localparam int SerialW     = 16;
  localparam int EntryW      = 32 + ConnW + SerialW;
  localparam int MaxResults  = 64;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0, ACT_DEL = 2'd1, ACT_EXPIRE = 2'd2, ACT_QUERY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0, KIND_ANSWER = 2'd1, KIND_DONE = 2'd2, KIND_FULL = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  conn_id;
    logic [30:0] timeout_ms;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         expired_conn;
    logic signed [31:0] remaining_ms;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        deadline;
    logic [ConnW-1:0]   conn;
    logic [SerialW-1:0] serial;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_LIVE,     // write live table, start push
    ST_PUSH_RD,      // read parent
    ST_PUSH_WAIT,
    ST_PUSH_CMP,
    ST_TOP_RD,       // read heap top
    ST_TOP_WAIT,
    ST_TOP_LIVE,     // read live table for top
    ST_TOP_CHK,
    ST_EMIT,
    ST_POP_LAST_RD,  // read last element
    ST_POP_LAST_WAIT,
    ST_POP_L_RD,
    ST_POP_R_RD,
    ST_POP_R_WAIT,
    ST_POP_CMP,
    ST_POP_CMP2,
    ST_FINISH,
    ST_OUT
  } state_t;

  // true when a comes before b in heap order
  function automatic logic entry_before(entry_t a, entry_t b);
    logic [31:0] d;
    d = a.deadline - b.deadline;
    if (d != 32'd0) return d[31];
    return a.serial < b.serial;
  endfunction
endpackage
`default_nettype wire

### rtl/deadline_timer_heap_top.sv
// deadline timer engine: a min-heap of (deadline, conn, serial) in ram plus
// a per-connection live serial table; stale heap entries drop out lazily
// channels: in (in_valid/in_ready/in_data) takes add, delete, expire, query;
// out (out_valid/out_ready/out_data) carries result items, last marks the
// final item of one input
// delete clears its live table entry from idle; add, expire and query step
// through the heap states, with one ram read port and one write port serving
// every heap move
// throughput: one input at a time; in_ready is low while an input works
// reset: heap count and next serial go to zero; the live table is cleared
// by a sweep of all 1024 entries after reset, one entry a cycle, with in_ready low
// a stalled receiver holds the engine in place: each result waits in the
// output register until taken; expire keeps one expired item back until the
// next due entry is found or the scan ends, so that last can be set on it
`default_nettype none
module deadline_timer_heap_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dth_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dth_pkg::out_item_t     out_data
);
  import dth_pkg::*;

  localparam int LiveW = SerialW + 1;
  localparam int LiveAw = $clog2(Connections);

  state_t state, state_next;
  in_item_t item;
  logic [CountW-1:0] count;
  logic [SerialW-1:0] next_serial;
  logic [LiveAw:0] clr_idx;
  logic clearing;
  logic [HeapAw-1:0] pos, child, parent;
  logic [6:0] n_out;
  entry_t cur, lchild, bestc;
  logic moved;
  logic [ConnW-1:0] held_conn;

  // heap ram
  logic h_we;
  logic [HeapAw-1:0] h_waddr, h_raddr;
  entry_t h_wdata, h_rdata;
  dth_ram #(.Width(EntryW), .Depth(HeapDepth)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata));

  // live serial table
  logic l_we;
  logic [LiveAw-1:0] l_waddr, l_raddr;
  logic [LiveW-1:0] l_wdata, l_rdata;
  dth_ram #(.Width(LiveW), .Depth(Connections)) u_live (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata));

  logic [31:0] top_diff;
  logic top_live, top_due, push_up, expire_act, l_first, r_first;
  logic out_free, emit_go, load_out;
  out_item_t out_next;
  logic [CountW-1:0] lidx, ridx;

  assign top_diff  = cur.deadline - item.now_ms;
  assign top_live  = l_rdata == {1'b1, cur.serial};
  assign top_due   = top_diff[31] || top_diff == 32'd0;
  assign expire_act = item.action == ACT_EXPIRE;
  assign lidx = {pos, 1'b1};
  assign ridx = lidx + CountW'(1);
  assign parent = (pos - HeapAw'(1)) >> 1;
  assign push_up = entry_before(cur, h_rdata);
  // sift step: left child against the moving entry, then right against the winner
  assign l_first = entry_before(lchild, cur);
  assign r_first = (ridx < count) && entry_before(h_rdata, l_first ? lchild : cur);
  assign out_free = !out_valid || out_ready;
  // the first expired item is only held, later ones release the held one
  assign emit_go = (n_out == 7'd0) || out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (!clearing && in_valid) begin
        case (in_data.action)
          ACT_ADD:    state_next = (count == CountW'(HeapDepth)) ? ST_FINISH
                                                                 : ST_ADD_LIVE;
          ACT_DEL:    state_next = ST_IDLE;
          default:    state_next = ST_TOP_RD;
        endcase
      end
      ST_ADD_LIVE:  state_next = (pos == '0) ? ST_IDLE : ST_PUSH_RD;
      ST_PUSH_RD:   state_next = (pos == '0) ? ST_IDLE : ST_PUSH_WAIT;
      ST_PUSH_WAIT: state_next = ST_PUSH_CMP;
      ST_PUSH_CMP:  state_next = push_up ? ST_PUSH_RD : ST_IDLE;
      ST_TOP_RD:    state_next = (count == '0) ? ST_FINISH : ST_TOP_WAIT;
      ST_TOP_WAIT:  state_next = ST_TOP_LIVE;
      ST_TOP_LIVE:  state_next = ST_TOP_CHK;
      ST_TOP_CHK: begin
        if (!top_live) state_next = ST_POP_LAST_RD;
        else if (expire_act && top_due && n_out != 7'(MaxResults))
          state_next = ST_EMIT;
        else state_next = ST_FINISH;
      end
      ST_EMIT:          if (emit_go) state_next = ST_POP_LAST_RD;
      ST_POP_LAST_RD:   state_next = (count == CountW'(1)) ? ST_TOP_RD
                                                           : ST_POP_LAST_WAIT;
      ST_POP_LAST_WAIT: state_next = ST_POP_L_RD;
      ST_POP_L_RD:      state_next = (lidx < count) ? ST_POP_R_RD : ST_TOP_RD;
      ST_POP_R_RD:      state_next = ST_POP_R_WAIT;
      ST_POP_R_WAIT:    state_next = ST_POP_CMP;
      ST_POP_CMP:       state_next = ST_POP_CMP2;
      ST_POP_CMP2:      state_next = moved ? ST_POP_L_RD : ST_TOP_RD;
      ST_FINISH:        if (out_free) state_next = ST_IDLE;
      default:          state_next = ST_IDLE;
    endcase
  end

  // memory and output controls
  always_comb begin
    h_we = 1'b0; h_waddr = pos; h_wdata = cur; h_raddr = '0;
    l_we = 1'b0; l_waddr = cur.conn; l_wdata = '0; l_raddr = cur.conn;
    in_ready = 1'b0;
    load_out = 1'b0;
    out_next = '0;
    if (clearing) begin
      l_we = 1'b1; l_waddr = clr_idx[LiveAw-1:0];
    end
    case (state)
      ST_IDLE: begin
        in_ready = !clearing;
        if (!clearing && in_valid && in_data.action == ACT_DEL) begin
          l_we = 1'b1; l_waddr = in_data.conn_id; l_wdata = '0;
        end
      end
      ST_ADD_LIVE: begin
        l_we = 1'b1; l_wdata = {1'b1, cur.serial};
        h_we = 1'b1;
      end
      // new entry goes into the hole while its parent is read
      ST_PUSH_RD: begin
        h_we = 1'b1;
        h_raddr = parent;
      end
      ST_PUSH_WAIT: h_raddr = parent;
      ST_PUSH_CMP: if (push_up) begin
        h_we = 1'b1; h_wdata = h_rdata;
      end
      ST_TOP_RD: h_raddr = '0;
      ST_TOP_LIVE: l_raddr = h_rdata.conn;
      ST_EMIT: if (emit_go) begin
        l_we = 1'b1;
        if (n_out != 7'd0) begin
          load_out = 1'b1;
          out_next.kind = KIND_EXPIRED;
          out_next.expired_conn = held_conn;
        end
      end
      ST_POP_LAST_RD: h_raddr = HeapAw'(count - CountW'(1));
      ST_POP_L_RD: begin
        h_raddr = lidx[HeapAw-1:0];
        if (!(lidx < count)) h_we = 1'b1;
      end
      ST_POP_R_RD: h_raddr = ridx[HeapAw-1:0];
      ST_POP_R_WAIT: h_raddr = ridx[HeapAw-1:0];
      ST_POP_CMP2: begin
        h_we = 1'b1;
        if (moved) h_wdata = bestc;
      end
      ST_FINISH: if (out_free) begin
        load_out = 1'b1;
        out_next.last = 1'b1;
        case (item.action)
          ACT_ADD: out_next.kind = KIND_FULL;
          ACT_QUERY: begin
            out_next.kind = KIND_ANSWER;
            out_next.remaining_ms = (count == '0) ? -32'sd1 :
                                    (top_diff[31] ? 32'sd0 : $signed(top_diff));
          end
          default: begin
            if (n_out == 7'd0) out_next.kind = KIND_DONE;
            else begin
              out_next.kind = KIND_EXPIRED;
              out_next.expired_conn = held_conn;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; count <= '0; next_serial <= '0;
      clr_idx <= '0; clearing <= 1'b1; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + (LiveAw+1)'(1);
        if (clr_idx == (LiveAw+1)'(Connections - 1)) clearing <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        out_data <= out_next;
      end else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (!clearing && in_valid) begin
          item <= in_data;
          n_out <= '0;
          cur.deadline <= in_data.now_ms + {1'b0, in_data.timeout_ms};
          cur.conn <= in_data.conn_id;
          cur.serial <= next_serial;
          pos <= HeapAw'(count);
        end
        ST_ADD_LIVE: begin
          count <= count + CountW'(1);
          next_serial <= next_serial + SerialW'(1);
        end
        ST_PUSH_CMP: if (push_up) pos <= parent;
        ST_TOP_WAIT: cur <= h_rdata;
        ST_EMIT: if (emit_go) begin
          held_conn <= cur.conn;
          n_out <= n_out + 7'd1;
        end
        ST_POP_LAST_RD: begin
          count <= count - CountW'(1);
          pos <= '0;
        end
        ST_POP_LAST_WAIT: cur <= h_rdata;
        ST_POP_R_RD: lchild <= h_rdata;
        ST_POP_CMP: begin
          moved <= l_first || r_first;
          if (r_first) begin
            bestc <= h_rdata; child <= ridx[HeapAw-1:0];
          end else begin
            bestc <= lchild; child <= lidx[HeapAw-1:0];
          end
        end
        ST_POP_CMP2: if (moved) pos <= child;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE && !clearing) else $error("ready outside idle");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(HeapDepth)) else $error("heap overflow");
  a_no_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready) else $error("accept during clear");
`endif
endmodule
`default_nettype wire

### rtl/dth_ram.sv
`default_nettype none
module dth_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
